/* rtl/pointer_report_builder_assert.svh */
// assertion macros for the pointer report builder
// expects clk and arst_n in the scope where a macro is used
`ifndef POINTER_REPORT_BUILDER_ASSERT_SVH
`define POINTER_REPORT_BUILDER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PRB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/prb_pkg.sv */
// shared types and constants for the pointer report builder
// no dependencies
package prb_pkg;

	localparam logic [7:0] ABS_DEVICE = 8'd1;
	localparam int ABS_SCALE  = 3;
	localparam int POS_LIMIT  = 32767;
	localparam int ABS_KNEE   = POS_LIMIT / ABS_SCALE;
	localparam int REL_SHIFT  = 4;
	localparam int STEP_SHIFT = 8;
	localparam int STEP_LIMIT = 127;

	typedef enum logic [1:0] {
		REPORT_NONE = 2'd0,
		REPORT_REL  = 2'd1,
		REPORT_ABS  = 2'd2
	} report_kind_t;

	typedef struct packed {
		logic               packet_valid;
		logic [7:0]         device_kind;
		logic signed [15:0] motion_x;
		logic signed [15:0] motion_y;
		logic [7:0]         button_byte;
		logic               host_ready;
	} prb_in_t;

	typedef struct packed {
		report_kind_t       report_kind;
		logic               button_mask;
		logic signed [7:0]  rel_dx;
		logic signed [7:0]  rel_dy;
		logic signed [15:0] abs_x;
		logic signed [15:0] abs_y;
	} prb_out_t;

	typedef struct packed {
		logic [15:0] acc_x;
		logic [15:0] acc_y;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  last_buttons;
		logic        mask_bit;
		logic        rel_pending;
		logic        abs_pending;
	} prb_state_t;

endpackage

/* rtl/prb_pass.sv */
// one loop pass: next state and report from the current state and one item
// depends on prb_pkg
module prb_pass (
	input  prb_pkg::prb_state_t st,
	input  prb_pkg::prb_in_t    item,
	output prb_pkg::prb_state_t st_next,
	output prb_pkg::prb_out_t   res
);
	import prb_pkg::*;

	typedef struct packed {
		logic signed [7:0] step;
		logic [15:0]       rest;
	} drain_t;

	function automatic logic [15:0] scale_abs(input logic signed [15:0] m);
		logic signed [17:0] p;
		p = (18'(m) <<< 1) + 18'(m);
		if (m >= ABS_KNEE)
			return 16'(POS_LIMIT);
		else if (m <= -ABS_KNEE)
			return 16'(-POS_LIMIT);
		else
			return p[15:0];
	endfunction

	function automatic logic is_small(input logic [15:0] v);
		return (v[15:8] == 8'h00) || (v[15:8] == 8'hFF && v[7:0] != 8'h00);
	endfunction

	function automatic drain_t drain(input logic [15:0] v);
		drain_t d;
		logic [7:0] q;
		q = v[15:8] + {7'd0, v[15] && (v[7:0] != 8'h00)};
		if (q == 8'h80)
			q = 8'(-STEP_LIMIT);
		d.step = q;
		d.rest = v - {q, {STEP_SHIFT{1'b0}}};
		return d;
	endfunction

	logic        abs_pkt;
	logic        rel_pkt;
	logic        btn_change;
	logic [15:0] acc_x1;
	logic [15:0] acc_y1;
	drain_t      dr_x;
	drain_t      dr_y;
	logic        pend_rel;

	assign abs_pkt    = item.packet_valid && (item.device_kind == ABS_DEVICE);
	assign rel_pkt    = item.packet_valid && (item.device_kind != ABS_DEVICE);
	assign btn_change = item.packet_valid && (item.button_byte != st.last_buttons);

	assign acc_x1 = rel_pkt ? st.acc_x + (item.motion_x << REL_SHIFT) : st.acc_x;
	assign acc_y1 = rel_pkt ? st.acc_y + (item.motion_y << REL_SHIFT) : st.acc_y;
	assign dr_x   = drain(acc_x1);
	assign dr_y   = drain(acc_y1);

	always_comb begin
		pend_rel = st.rel_pending || rel_pkt;
		if (is_small(acc_x1) || is_small(acc_y1))
			pend_rel = 1'b0;
		if (dr_x.step != 8'sd0 || dr_y.step != 8'sd0)
			pend_rel = 1'b1;
		if (btn_change)
			pend_rel = 1'b1;
	end

	always_comb begin
		st_next              = st;
		st_next.acc_x        = dr_x.rest;
		st_next.acc_y        = dr_y.rest;
		st_next.pos_x        = abs_pkt ? scale_abs(item.motion_x) : st.pos_x;
		st_next.pos_y        = abs_pkt ? scale_abs(item.motion_y) : st.pos_y;
		st_next.abs_pending  = st.abs_pending || abs_pkt;
		st_next.rel_pending  = pend_rel;
		st_next.last_buttons = btn_change ? item.button_byte : st.last_buttons;
		st_next.mask_bit     = btn_change ? (item.button_byte == 8'h00) : st.mask_bit;
		res.report_kind      = REPORT_NONE;
		if (item.host_ready) begin
			if (pend_rel) begin
				res.report_kind     = REPORT_REL;
				st_next.rel_pending = 1'b0;
			end else if (st_next.abs_pending) begin
				res.report_kind     = REPORT_ABS;
				st_next.abs_pending = 1'b0;
			end
		end
		res.button_mask = st_next.mask_bit;
		res.rel_dx      = dr_x.step;
		res.rel_dy      = dr_y.step;
		res.abs_x       = st_next.pos_x;
		res.abs_y       = st_next.pos_y;
	end

endmodule

/* rtl/pointer_report_builder.sv */
// pointer report builder top level: input register, pass logic, report register
// depends on prb_pkg, prb_pass and pointer_report_builder_assert.svh
//
// Each transferred item is one polling pass and yields exactly one report item.
// The block sustains one item per clock while reports are not stalled: an item
// waits in the input register, and as it fires the pass logic updates the
// accumulator, position and flag registers and loads the report register with
// them, so each item passes the input register and then the report register.
// The rate is set by the loop through the state registers; a stalled report holds
// and item_stall rises only while the input and report registers are both full.
`include "pointer_report_builder_assert.svh"

module pointer_report_builder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  prb_pkg::prb_in_t  item,
	output logic              report_valid,
	input  logic              report_stall,
	output prb_pkg::prb_out_t report
);
	import prb_pkg::*;

	prb_in_t    item_s1;
	logic       valid_s1;
	prb_state_t st_q;
	prb_state_t st_next;
	prb_out_t   res_next;
	prb_out_t   report_q;
	logic       report_valid_q;
	logic       fire;

	assign fire       = valid_s1 && (!report_valid_q || !report_stall);
	assign item_stall = valid_s1 && !fire;

	prb_pass u_pass (
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			report_valid_q <= 1'b0;
			st_q           <= '0;
		end else begin
			if (!item_stall)
				valid_s1 <= item_valid;
			if (fire) begin
				st_q           <= st_next;
				report_valid_q <= 1'b1;
			end else if (!report_stall) begin
				report_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
		if (fire)
			report_q <= res_next;
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

	`PRB_ASSERT_SAME(a_acc_x_residue, 1'b1,
		st_q.acc_x[15:8] == 8'h00 || st_q.acc_x[15:8] == 8'hFF,
		"x accumulator kept a whole step")
	`PRB_ASSERT_SAME(a_acc_y_residue, 1'b1,
		st_q.acc_y[15:8] == 8'h00 || st_q.acc_y[15:8] == 8'hFF,
		"y accumulator kept a whole step")
	`PRB_ASSERT_SAME(a_abs_needs_pending, fire && res_next.report_kind == REPORT_ABS,
		st_q.abs_pending || (item_s1.packet_valid && item_s1.device_kind == ABS_DEVICE),
		"absolute report with nothing pending")
	`PRB_ASSERT_NEXT(a_rel_sent_clears, fire && res_next.report_kind == REPORT_REL,
		!st_q.rel_pending, "relative pending not cleared after transfer")
	`PRB_ASSERT_SAME(a_stall_needs_item, item_stall, valid_s1 && report_valid_q,
		"input stalled with room downstream")

endmodule

/* dv/pointer_report_builder_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for pointer_report_builder: directed and random passes
// checked against an in-bench model of the pass logic; depends on prb_pkg and pointer_report_builder

module pointer_report_builder_tb;
	import prb_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int LONG_HOLD   = 60;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_stall;
	prb_in_t  item = '0;
	logic     report_valid;
	logic     report_stall = 1'b0;
	prb_out_t report;

	// model state of the pass logic
	logic signed [15:0] sum_x, sum_y, place_x, place_y;
	logic [7:0]         held_buttons;
	logic               button_bit, rel_due, abs_due;

	prb_out_t owed_reports[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       passes_sent = 0;
	int       rel_seen = 0, abs_seen = 0, none_seen = 0;
	bit       no_gaps = 1'b0;
	bit       hold_request = 1'b0;
	logic [7:0] btn_now = 8'd0;

	pointer_report_builder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [15:0] scale_position(input logic signed [15:0] m);
		int v;
		v = m;
		if (v >= ABS_KNEE)
			return 16'(POS_LIMIT);
		else if (v <= -ABS_KNEE)
			return 16'(-POS_LIMIT);
		return 16'(v * ABS_SCALE);
	endfunction

	function automatic logic signed [7:0] drain_step(inout logic signed [15:0] sum);
		int q;
		q = int'(sum) / (1 << STEP_SHIFT);
		if (q < -STEP_LIMIT)
			q = -STEP_LIMIT;
		if (q != 0) begin
			sum = 16'(int'(sum) - q * (1 << STEP_SHIFT));
			rel_due = 1'b1;
		end
		return 8'(q);
	endfunction

	function automatic prb_out_t build_report(input prb_in_t p);
		prb_out_t r;
		int vx, vy;
		r = '0;
		if (p.packet_valid) begin
			if (p.device_kind == ABS_DEVICE) begin
				place_x = scale_position(p.motion_x);
				place_y = scale_position(p.motion_y);
				abs_due = 1'b1;
			end else begin
				sum_x = sum_x + (p.motion_x <<< REL_SHIFT);
				sum_y = sum_y + (p.motion_y <<< REL_SHIFT);
				rel_due = 1'b1;
			end
		end
		vx = sum_x;
		vy = sum_y;
		// small residue on either axis drops the pending relative report
		if ((vx < 0 ? -vx : vx) < (1 << STEP_SHIFT) || (vy < 0 ? -vy : vy) < (1 << STEP_SHIFT))
			rel_due = 1'b0;
		r.rel_dx = drain_step(sum_x);
		r.rel_dy = drain_step(sum_y);
		if (p.packet_valid && p.button_byte != held_buttons) begin
			held_buttons = p.button_byte;
			button_bit = (p.button_byte == 8'd0);
			rel_due = 1'b1;
		end
		r.report_kind = REPORT_NONE;
		if (p.host_ready) begin
			if (rel_due) begin
				r.report_kind = REPORT_REL;
				rel_due = 1'b0;
			end else if (abs_due) begin
				r.report_kind = REPORT_ABS;
				abs_due = 1'b0;
			end
		end
		r.button_mask = button_bit;
		r.abs_x = place_x;
		r.abs_y = place_y;
		return r;
	endfunction

	function automatic prb_in_t mk_pass(bit v, logic [7:0] k, int mx, int my,
			logic [7:0] b, bit rdy);
		prb_in_t p;
		p.packet_valid = v;
		p.device_kind = k;
		p.motion_x = 16'(mx);
		p.motion_y = 16'(my);
		p.button_byte = b;
		p.host_ready = rdy;
		return p;
	endfunction

	function automatic int random_motion();
		case ($urandom_range(0, 9))
			0:       return int'($urandom_range(0, 65535)) - 32768;
			1, 2:    return int'($urandom_range(0, 4096)) - 2048;
			default: return int'($urandom_range(0, 300)) - 150;
		endcase
	endfunction

	function automatic prb_in_t random_pass();
		prb_in_t p;
		p.packet_valid = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 7))
			0, 1:    p.device_kind = ABS_DEVICE;
			2:       p.device_kind = 8'($urandom);
			default: p.device_kind = 8'd0;
		endcase
		p.motion_x = 16'(random_motion());
		p.motion_y = 16'(random_motion());
		case ($urandom_range(0, 9))
			0:       btn_now = 8'd0;
			1:       btn_now = 8'($urandom);
			default: ;
		endcase
		p.button_byte = btn_now;
		p.host_ready = ($urandom_range(0, 3) != 0);
		return p;
	endfunction

	task automatic send_pass(input prb_in_t p);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= p;
		do @(posedge clk); while (item_stall);
		owed_reports.push_back(build_report(p));
		passes_sent++;
	endtask

	task automatic wait_reports_done();
		item_valid <= 1'b0;
		while (owed_reports.size() != 0)
			@(posedge clk);
	endtask

	// receiver: per transfer a random hold-off, or one long stretch on request
	initial begin
		int n;
		forever begin
			if (hold_request) begin
				n = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				n = no_gaps ? 0 : $urandom_range(0, 8);
			end
			if (n > 0) begin
				report_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			report_stall <= 1'b0;
			do @(posedge clk); while (!(report_valid && !report_stall));
		end
	end

	always @(posedge clk) begin
		prb_out_t want;
		if (arst_n && report_valid && !report_stall) begin
			if (owed_reports.size() == 0) begin
				$error("report transfer with no pass outstanding");
				mismatch_count++;
			end else begin
				want = owed_reports.pop_front();
				case (want.report_kind)
					REPORT_REL: rel_seen++;
					REPORT_ABS: abs_seen++;
					default:    none_seen++;
				endcase
				if (report.report_kind !== want.report_kind) begin
					$error("report_kind: expected %0d, got %0d", want.report_kind,
						report.report_kind);
					mismatch_count++;
				end
				if (report.button_mask !== want.button_mask) begin
					$error("button_mask: expected %0d, got %0d", want.button_mask,
						report.button_mask);
					mismatch_count++;
				end
				if (report.rel_dx !== want.rel_dx) begin
					$error("rel_dx: expected %0d, got %0d", want.rel_dx, report.rel_dx);
					mismatch_count++;
				end
				if (report.rel_dy !== want.rel_dy) begin
					$error("rel_dy: expected %0d, got %0d", want.rel_dy, report.rel_dy);
					mismatch_count++;
				end
				if (report.abs_x !== want.abs_x) begin
					$error("abs_x: expected %0d, got %0d", want.abs_x, report.abs_x);
					mismatch_count++;
				end
				if (report.abs_y !== want.abs_y) begin
					$error("abs_y: expected %0d, got %0d", want.abs_y, report.abs_y);
					mismatch_count++;
				end
			end
		end
	end

	// saturation knees and extremes of absolute packets
	task automatic test_absolute_scaling();
		send_pass(mk_pass(1, ABS_DEVICE, 32767, -32768, 8'd0, 1));
		send_pass(mk_pass(1, ABS_DEVICE, 10922, -10922, 8'd0, 1));
		send_pass(mk_pass(1, ABS_DEVICE, 10921, -10921, 8'd0, 0));
		send_pass(mk_pass(1, ABS_DEVICE, 0, 0, 8'd0, 1));
		send_pass(mk_pass(1, ABS_DEVICE, -1, 1, 8'd0, 1));
		wait_reports_done();
	endtask

	// accumulation, clamp of the negative full step, wrap and small residue
	task automatic test_relative_drain();
		send_pass(mk_pass(1, 8'd0, 16, 16, 8'd0, 1));
		send_pass(mk_pass(1, 8'd0, -2048, -2048, 8'd0, 0));
		send_pass(mk_pass(0, 8'd0, 0, 0, 8'd0, 1));
		send_pass(mk_pass(1, 8'd0, 2047, 2047, 8'd0, 1));
		send_pass(mk_pass(1, 8'd0, 5, 0, 8'd0, 1));
		send_pass(mk_pass(1, 8'hFF, -32768, 32767, 8'd0, 1));
		send_pass(mk_pass(1, 8'd2, 1, -1, 8'd0, 1));
		send_pass(mk_pass(0, ABS_DEVICE, -32768, 32767, 8'hFF, 1));
		wait_reports_done();
	endtask

	// button toggles, host not ready, and relative before absolute
	task automatic test_buttons_and_ready();
		send_pass(mk_pass(1, 8'd0, 0, 0, 8'hFF, 0));
		send_pass(mk_pass(1, ABS_DEVICE, 100, -100, 8'hFF, 1));
		send_pass(mk_pass(1, ABS_DEVICE, -200, 300, 8'd0, 1));
		send_pass(mk_pass(1, 8'd0, 40, 40, 8'hA5, 1));
		send_pass(mk_pass(1, 8'd7, 0, 0, 8'h5A, 1));
		send_pass(mk_pass(0, 8'd0, 0, 0, 8'h00, 1));
		wait_reports_done();
	endtask

	task automatic test_random_passes(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_pass(random_pass());
		end
		no_gaps = 1'b0;
		wait_reports_done();
	endtask

	// receiver holds off long while passes keep coming, so input stalls
	task automatic test_full_backpressure();
		hold_request = 1'b1;
		no_gaps = 1'b1;
		for (int i = 0; i < 25; i++)
			send_pass(random_pass());
		no_gaps = 1'b0;
		wait_reports_done();
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		for (int i = 0; i < 40; i++)
			send_pass(random_pass());
		wait_reports_done();
		no_gaps = 1'b0;
	endtask

	initial begin
		sum_x = '0;
		sum_y = '0;
		place_x = '0;
		place_y = '0;
		held_buttons = '0;
		button_bit = 1'b0;
		rel_due = 1'b0;
		abs_due = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_absolute_scaling();
		test_relative_drain();
		test_buttons_and_ready();
		test_random_passes(460);
		test_full_backpressure();
		test_back_to_back();
		repeat (10) @(posedge clk);
		$display("passes sent: %0d; reports checked: %0d relative, %0d absolute, %0d empty",
			passes_sent, rel_seen, abs_seen, none_seen);
		$display("mismatches: %0d", mismatch_count);
		if (mismatch_count == 0 && owed_reports.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/prb_pkg.sv
rtl/prb_pass.sv
rtl/pointer_report_builder.sv
dv/pointer_report_builder_tb.sv
